// ===== hw/rtl/hw_monitor_reading_converter_macros.svh =====
// Assertion macros for the reading converter.
// Both forms sample on clk and are switched off while arst_n is low.
`ifndef HW_MONITOR_READING_CONVERTER_MACROS_SVH
`define HW_MONITOR_READING_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define HWMRC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hwmrc assertion failed");
`define HWMRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("hwmrc assertion failed");
`else
`define HWMRC_ASSERT_IMPL(lbl, ante, cons)
`define HWMRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/hwmrc_pkg.sv =====
package hwmrc_pkg;

	// Reading kinds carried in the cmd field.
	localparam logic [1:0] CMD_VOLTAGE = 2'd0;
	localparam logic [1:0] CMD_TEMP    = 2'd1;
	localparam logic [1:0] CMD_FAN     = 2'd2;
	localparam logic [1:0] CMD_PWM     = 2'd3;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FAN_WIDE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FAN_DIV   = 2'd2;

	// Voltage step modes and their steps in 0.1 mV.
	localparam logic [1:0] STEP_MODE_12MV   = 2'd1;
	localparam logic [1:0] STEP_MODE_10P9MV = 2'd2;
	localparam logic [7:0] STEP_16MV   = 8'd160;
	localparam logic [7:0] STEP_12MV   = 8'd120;
	localparam logic [7:0] STEP_10P9MV = 8'd109;

	localparam int RAW_W    = 16;
	localparam int DIRECT_W = 16;
	localparam int VALUE_W  = 21;
	localparam int SHIFT_W  = 3;

	// Fan speed divider: a constant dividend over a 16-bit count.
	localparam int QUOT_W             = VALUE_W;
	localparam int COUNT_W            = RAW_W;
	localparam int DIV_BITS_PER_STAGE = 3;
	localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;
	localparam logic [QUOT_W-1:0] FAN_RPM_CONST = 21'd1350000;

	localparam logic [RAW_W-1:0]   FAN_WIDE_MIN  = 16'd64;
	localparam logic [RAW_W-1:0]   FAN_WIDE_OVF  = 16'hFFFF;
	localparam logic [7:0]         FAN_NARROW_OVF = 8'hFF;
	localparam logic [SHIFT_W-1:0] FAN_SHIFT_DEF = 3'd1;

	// Duty percent for each 7-bit PWM value, rounded.
	localparam int DUTY_W       = 7;
	localparam int DUTY_ENTRIES = 128;

	function automatic logic [DUTY_ENTRIES*DUTY_W-1:0] build_duty_lut();
		logic [DUTY_ENTRIES*DUTY_W-1:0] lut;
		lut = '0;
		for (int i = 0; i < DUTY_ENTRIES; i++) begin
			lut[i*DUTY_W +: DUTY_W] = DUTY_W'((i * 100 + 63) / 127);
		end
		return lut;
	endfunction

	localparam logic [DUTY_ENTRIES*DUTY_W-1:0] DUTY_LUT = build_duty_lut();

	typedef struct packed {
		logic [1:0]       cmd;
		logic [3:0]       channel;
		logic [RAW_W-1:0] raw_value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] converted_value;
		logic               reading_valid;
	} rsp_t;

	// Side information that travels alongside the divider.
	typedef struct packed {
		logic                ok;
		logic                fan;
		logic [SHIFT_W-1:0]  shift;
		logic [DIRECT_W-1:0] direct;
	} tag_t;

endpackage

// ===== hw/rtl/hwmrc_divider.sv =====
module hwmrc_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [hwmrc_pkg::COUNT_W-1:0]     divisor,
	input  hwmrc_pkg::tag_t                   in_tag,
	output logic                              out_valid,
	output logic [hwmrc_pkg::QUOT_W-1:0]      quotient,
	output hwmrc_pkg::tag_t                   out_tag
);

	localparam int STAGES = hwmrc_pkg::DIV_STAGES;
	localparam int BPS    = hwmrc_pkg::DIV_BITS_PER_STAGE;
	localparam int CW     = hwmrc_pkg::COUNT_W;
	localparam int QW     = hwmrc_pkg::QUOT_W;

	logic                  valid_s [STAGES];
	logic [CW-1:0]         rem_s   [STAGES];
	logic [QW-1:0]         quo_s   [STAGES];
	logic [CW-1:0]         den_s   [STAGES];
	hwmrc_pkg::tag_t       tag_s   [STAGES];

	logic                  valid_prev [STAGES];
	logic [CW-1:0]         rem_prev   [STAGES];
	logic [QW-1:0]         quo_prev   [STAGES];
	logic [CW-1:0]         den_prev   [STAGES];
	hwmrc_pkg::tag_t       tag_prev   [STAGES];

	logic [CW-1:0]         rem_next   [STAGES];
	logic [QW-1:0]         quo_next   [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign valid_prev[g] = in_valid;
			assign rem_prev[g]   = '0;
			assign quo_prev[g]   = '0;
			assign den_prev[g]   = divisor;
			assign tag_prev[g]   = in_tag;
		end else begin : g_rest
			assign valid_prev[g] = valid_s[g-1];
			assign rem_prev[g]   = rem_s[g-1];
			assign quo_prev[g]   = quo_s[g-1];
			assign den_prev[g]   = den_s[g-1];
			assign tag_prev[g]   = tag_s[g-1];
		end

		// Restoring division, a few quotient bits per stage. The remainder
		// stays below the divisor, so it always fits the count width.
		always_comb begin : p_step
			logic [CW:0]   trial;
			logic [CW-1:0] rem;
			logic [QW-1:0] quo;
			logic          qbit;
			rem = rem_prev[g];
			quo = quo_prev[g];
			for (int b = 0; b < BPS; b++) begin
				trial = {rem, hwmrc_pkg::FAN_RPM_CONST[QW-1-g*BPS-b]};
				qbit  = (trial >= {1'b0, den_prev[g]});
				if (qbit) begin
					trial = trial - {1'b0, den_prev[g]};
				end
				rem = trial[CW-1:0];
				quo = {quo[QW-2:0], qbit};
			end
			rem_next[g] = rem;
			quo_next[g] = quo;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else begin
				valid_s[g] <= valid_prev[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= rem_next[g];
			quo_s[g] <= quo_next[g];
			den_s[g] <= den_prev[g];
			tag_s[g] <= tag_prev[g];
		end
	end

	assign out_valid = valid_s[STAGES-1];
	assign quotient  = quo_s[STAGES-1];
	assign out_tag   = tag_s[STAGES-1];

endmodule

// ===== hw/rtl/hw_monitor_reading_converter.sv =====
// Hardware-monitor reading converter.
// Input beat: pulse start with req (cmd, channel, raw_value); it is taken at
// any clock edge where start is high and busy is low. busy never rises, so a
// new reading can be taken on every clock.
// Result beat: done is high for exactly one cycle with rsp (converted_value,
// reading_valid); the receiver must take it in that cycle.
// Pipeline: every kind of reading passes the decode stage register, the
// 7-stage pipelined divider that turns fan counts into RPM (3 quotient bits
// per stage) and the output register. Throughput is one reading per cycle.
// Results come out in the order readings went in.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at that
// edge; indexes beyond the register list are ignored. Write only while no
// reading is in flight.
// Reset: arst_n clears all in-flight readings and returns the registers to
// 16 mV step, 16-bit fan counters and zero divisor exponents.
`include "hw_monitor_reading_converter_macros.svh"

module hw_monitor_reading_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  hwmrc_pkg::req_t                     req,
	output logic                                done,
	output hwmrc_pkg::rsp_t                     rsp,
	input  logic                                cfg_we,
	input  logic [hwmrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [hwmrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int LATENCY = hwmrc_pkg::DIV_STAGES + 2;

	logic [1:0] step_mode_q;
	logic       fan_wide_q;
	logic [5:0] fan_div_q;

	logic                              accept;
	logic [7:0]                        lo;
	logic [7:0]                        step;
	logic [hwmrc_pkg::COUNT_W-1:0]     count_d;
	hwmrc_pkg::tag_t                   tag_d;

	logic                              valid_s1;
	logic [hwmrc_pkg::COUNT_W-1:0]     count_s1;
	hwmrc_pkg::tag_t                   tag_s1;

	logic                              div_valid;
	logic [hwmrc_pkg::QUOT_W-1:0]      div_quot;
	hwmrc_pkg::tag_t                   div_tag;
	logic [hwmrc_pkg::VALUE_W-1:0]     value_d;

	logic                              done_q;
	hwmrc_pkg::rsp_t                   rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_mode_q <= '0;
			fan_wide_q  <= 1'b1;
			fan_div_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hwmrc_pkg::REG_STEP_MODE: step_mode_q <= cfg_wdata[1:0];
				hwmrc_pkg::REG_FAN_WIDE:  fan_wide_q  <= cfg_wdata[0];
				hwmrc_pkg::REG_FAN_DIV:   fan_div_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (step_mode_q)
			hwmrc_pkg::STEP_MODE_12MV:   step = hwmrc_pkg::STEP_12MV;
			hwmrc_pkg::STEP_MODE_10P9MV: step = hwmrc_pkg::STEP_10P9MV;
			default:                     step = hwmrc_pkg::STEP_16MV;
		endcase
	end

	// Decode stage: every kind but fan speed is finished here; a fan count
	// goes to the divider, and the divisor power of two becomes a right shift
	// of the quotient at the end.
	always_comb begin
		lo           = req.raw_value[7:0];
		count_d      = '0;
		tag_d.ok     = 1'b0;
		tag_d.fan    = 1'b0;
		tag_d.shift  = hwmrc_pkg::FAN_SHIFT_DEF;
		tag_d.direct = '0;
		unique case (req.cmd)
			hwmrc_pkg::CMD_VOLTAGE: begin
				tag_d.ok     = (lo != 8'd0);
				tag_d.direct = hwmrc_pkg::DIRECT_W'(lo) * hwmrc_pkg::DIRECT_W'(step);
			end
			hwmrc_pkg::CMD_TEMP: begin
				tag_d.ok     = (lo != 8'd0) && !lo[7];
				tag_d.direct = hwmrc_pkg::DIRECT_W'(lo);
			end
			hwmrc_pkg::CMD_FAN: begin
				tag_d.fan = 1'b1;
				if (fan_wide_q) begin
					count_d  = req.raw_value;
					tag_d.ok = (req.raw_value >= hwmrc_pkg::FAN_WIDE_MIN) &&
						(req.raw_value != hwmrc_pkg::FAN_WIDE_OVF);
				end else begin
					count_d  = hwmrc_pkg::COUNT_W'(lo);
					tag_d.ok = (lo != 8'd0) && (lo != hwmrc_pkg::FAN_NARROW_OVF);
					if (req.channel == 4'd0) begin
						tag_d.shift = fan_div_q[2:0];
					end else if (req.channel == 4'd1) begin
						tag_d.shift = fan_div_q[5:3];
					end
				end
			end
			default: begin
				tag_d.ok     = !lo[7];
				tag_d.direct = hwmrc_pkg::DIRECT_W'(
					hwmrc_pkg::DUTY_LUT[lo[6:0]*hwmrc_pkg::DUTY_W +: hwmrc_pkg::DUTY_W]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		count_s1 <= count_d;
		tag_s1   <= tag_d;
	end

	hwmrc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.divisor   (count_s1),
		.in_tag    (tag_s1),
		.out_valid (div_valid),
		.quotient  (div_quot),
		.out_tag   (div_tag)
	);

	always_comb begin
		if (!div_tag.ok) begin
			value_d = '0;
		end else if (div_tag.fan) begin
			value_d = div_quot >> div_tag.shift;
		end else begin
			value_d = hwmrc_pkg::VALUE_W'(div_tag.direct);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.converted_value <= value_d;
		rsp_q.reading_valid   <= div_tag.ok;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Every result beat traces back to exactly one accepted reading.
	`HWMRC_ASSERT_IMPL(a_done_has_source, done, $past(accept, LATENCY))
	// An accepted reading always produces its result after the fixed latency.
	`HWMRC_ASSERT_NEXT(a_accept_gives_done, accept, ##(LATENCY-1) done)
	// Invalid readings report a zero value, including a fan count of zero.
	`HWMRC_ASSERT_IMPL(a_invalid_is_zero, done && !rsp.reading_valid, rsp.converted_value == '0)

endmodule

// ===== tb/hwmrc_reading_checker.sv =====
`timescale 1ns / 100ps

// Watches the reading and register ports of the converter and keeps its own
// copy of the three registers. It predicts each result and checks the results
// in arrival order.
module hwmrc_reading_checker
	import hwmrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  req_t                   req,
	input  logic                   done,
	input  rsp_t                   rsp,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                     mismatches,
	output int                     readings_pending,
	output int                     readings_checked,
	output int                     readings_valid
);

	localparam int unsigned RPM_DIVIDEND = 1350000;

	logic [1:0] step_mode;
	logic       fan_wide;
	logic [5:0] fan_div_exps;
	rsp_t       expected_readings[$];

	function automatic rsp_t convert_reading(input req_t r);
		logic [7:0]  lo;
		int unsigned step;
		int unsigned divisor;
		int unsigned value;
		rsp_t        res;
		lo = r.raw_value[7:0];
		value = 0;
		res = '0;
		case (step_mode)
			STEP_MODE_12MV:   step = 32'(STEP_12MV);
			STEP_MODE_10P9MV: step = 32'(STEP_10P9MV);
			default:          step = 32'(STEP_16MV);
		endcase
		case (r.cmd)
			CMD_VOLTAGE: begin
				if (lo != 8'd0) begin
					value = int'(lo) * step;
					res.reading_valid = 1'b1;
				end
			end
			CMD_TEMP: begin
				if (lo >= 8'd1 && lo <= 8'd127) begin
					value = 32'(lo);
					res.reading_valid = 1'b1;
				end
			end
			CMD_FAN: begin
				if (fan_wide) begin
					if (r.raw_value >= 16'd64 && r.raw_value <= 16'd65534) begin
						value = RPM_DIVIDEND / (int'(r.raw_value) * 2);
						res.reading_valid = 1'b1;
					end
				end else begin
					// Only fans 0 and 1 have a programmable divisor.
					divisor = 2;
					if (r.channel == 4'd0)
						divisor = 1 << fan_div_exps[2:0];
					else if (r.channel == 4'd1)
						divisor = 1 << fan_div_exps[5:3];
					if (lo >= 8'd1 && lo <= 8'd254) begin
						value = RPM_DIVIDEND / (int'(lo) * divisor);
						res.reading_valid = 1'b1;
					end
				end
			end
			default: begin
				// Bit 7 set means the fan runs in automatic mode.
				if (!lo[7]) begin
					value = (int'(lo[6:0]) * 100 + 63) / 127;
					res.reading_valid = 1'b1;
				end
			end
		endcase
		res.converted_value = VALUE_W'(value);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   errs;
		errs = 0;
		if (!arst_n) begin
			step_mode <= 2'd0;
			fan_wide <= 1'b1;
			fan_div_exps <= 6'd0;
			expected_readings.delete();
			mismatches <= 0;
			readings_checked <= 0;
			readings_valid <= 0;
		end else begin
			if (done) begin
				if (expected_readings.size() == 0) begin
					$error("result beat with no reading outstanding: value %0d valid %0b",
						rsp.converted_value, rsp.reading_valid);
					errs = errs + 1;
				end else begin
					want = expected_readings.pop_front();
					readings_checked <= readings_checked + 1;
					if (want.reading_valid)
						readings_valid <= readings_valid + 1;
					if (rsp.converted_value !== want.converted_value) begin
						$error("converted_value mismatch: expected %0d, actual %0d",
							want.converted_value, rsp.converted_value);
						errs = errs + 1;
					end
					if (rsp.reading_valid !== want.reading_valid) begin
						$error("reading_valid mismatch: expected %0b, actual %0b",
							want.reading_valid, rsp.reading_valid);
						errs = errs + 1;
					end
				end
			end
			if (errs != 0)
				mismatches <= mismatches + errs;
			if (start && !busy)
				expected_readings.push_back(convert_reading(req));
			// Writes to the unused index must leave every register alone.
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_MODE: step_mode <= cfg_wdata[1:0];
					REG_FAN_WIDE:  fan_wide <= cfg_wdata[0];
					REG_FAN_DIV:   fan_div_exps <= cfg_wdata[5:0];
					default:       ;
				endcase
			end
		end
	end

	assign readings_pending = expected_readings.size();

endmodule

// ===== tb/tb_hw_monitor_reading_converter.sv =====
`timescale 1ns / 100ps

module tb_hw_monitor_reading_converter;
	import hwmrc_pkg::*;

	localparam int                     PHASES          = 8;
	localparam int                     RANDOM_PER_PHASE = 112;
	localparam int                     SETTLE_CYCLES   = 12;
	localparam int                     IDLE_LIMIT      = 2000;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED      = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	req_t                   req;
	logic                   done;
	rsp_t                   rsp;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	int mismatches;
	int readings_pending;
	int readings_checked;
	int readings_valid;
	int idle_cycles;
	int settings_used;

	hw_monitor_reading_converter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	hwmrc_reading_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req              (req),
		.done             (done),
		.rsp              (rsp),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.mismatches       (mismatches),
		.readings_pending (readings_pending),
		.readings_checked (readings_checked),
		.readings_valid   (readings_valid)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Ends the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic req_t make_req(input logic [1:0] cmd, input logic [3:0] channel,
			input logic [15:0] raw_value);
		req_t r;
		r.cmd = cmd;
		r.channel = channel;
		r.raw_value = raw_value;
		return r;
	endfunction

	function automatic req_t random_reading();
		req_t r;
		r.cmd = 2'($urandom_range(0, 3));
		r.channel = 4'($urandom_range(0, 15));
		if (r.cmd == CMD_FAN && $urandom_range(0, 1) == 1)
			r.channel = 4'($urandom_range(0, 1));
		r.raw_value = 16'($urandom_range(0, 65535));
		// Bias a share of beats onto the range limits of every kind.
		case ($urandom_range(0, 11))
			0: r.raw_value[7:0] = 8'd0;
			1: r.raw_value[7:0] = 8'd1;
			2: r.raw_value[7:0] = 8'd127;
			3: r.raw_value[7:0] = 8'd128;
			4: r.raw_value[7:0] = 8'd254;
			5: r.raw_value[7:0] = 8'd255;
			6: r.raw_value = 16'($urandom_range(60, 70));
			7: r.raw_value = 16'($urandom_range(65530, 65535));
			default: ;
		endcase
		return r;
	endfunction

	// Holds start high until the beat is taken; start stays high on return so
	// that a following beat with no gap goes out on the very next edge.
	task automatic send_reading(input req_t r, input int gap);
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_readings();
		start <= 1'b0;
		@(posedge clk);
		while (readings_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [1:0] mode, input logic wide,
			input logic [5:0] div_exps);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		data[1:0] = mode;
		cfg_we <= 1'b1;
		cfg_index <= REG_STEP_MODE;
		cfg_wdata <= data;
		@(posedge clk);
		data = CFG_DATA_W'($urandom);
		data[0] = wide;
		cfg_index <= REG_FAN_WIDE;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_index <= REG_FAN_DIV;
		cfg_wdata <= div_exps;
		@(posedge clk);
		if ($urandom_range(0, 1) == 1) begin
			cfg_index <= REG_UNUSED;
			cfg_wdata <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_random_readings(input int count);
		bit no_gaps;
		no_gaps = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			send_reading(random_reading(), no_gaps ? 0 : $urandom_range(0, 4));
		end
	endtask

	initial begin
		logic [1:0] modes[PHASES];
		logic       wides[PHASES];
		logic [5:0] divs[PHASES];

		modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd2, 2'd1};
		wides = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
		divs  = '{6'd0, 6'o70, 6'o77, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
		modes[5] = 2'($urandom_range(0, 3));
		wides[5] = 1'($urandom_range(0, 1));
		divs[3] = 6'($urandom_range(0, 63));
		divs[4] = 6'($urandom_range(0, 63));
		divs[5] = 6'($urandom_range(0, 63));
		divs[7] = 6'($urandom_range(0, 63));

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_cycles = 0;
		settings_used = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 16 mV step and 16-bit fan counters.
		send_reading(make_req(CMD_VOLTAGE, 4'd0, 16'h0000), 0);
		send_reading(make_req(CMD_VOLTAGE, 4'd3, 16'h0001), 1);
		send_reading(make_req(CMD_VOLTAGE, 4'd8, 16'h00FF), 0);
		send_reading(make_req(CMD_VOLTAGE, 4'd2, 16'hFF00), 0);
		send_reading(make_req(CMD_TEMP, 4'd0, 16'h0000), 2);
		send_reading(make_req(CMD_TEMP, 4'd1, 16'h0001), 0);
		send_reading(make_req(CMD_TEMP, 4'd5, 16'h007F), 0);
		send_reading(make_req(CMD_TEMP, 4'd7, 16'h0080), 0);
		send_reading(make_req(CMD_TEMP, 4'd4, 16'h3CFF), 0);
		send_reading(make_req(CMD_FAN, 4'd0, 16'd63), 0);
		send_reading(make_req(CMD_FAN, 4'd1, 16'd64), 0);
		send_reading(make_req(CMD_FAN, 4'd15, 16'd65534), 0);
		send_reading(make_req(CMD_FAN, 4'd6, 16'd65535), 0);
		send_reading(make_req(CMD_FAN, 4'd0, 16'd0), 0);
		send_reading(make_req(CMD_PWM, 4'd0, 16'h0000), 3);
		send_reading(make_req(CMD_PWM, 4'd9, 16'h007F), 0);
		send_reading(make_req(CMD_PWM, 4'd1, 16'h0080), 0);
		send_reading(make_req(CMD_PWM, 4'd12, 16'hA5FF), 0);
		send_reading(make_req(CMD_PWM, 4'd2, 16'h1240), 0);
		send_random_readings(RANDOM_PER_PHASE);

		for (int p = 1; p < PHASES; p++) begin
			drain_readings();
			write_settings(modes[p], wides[p], divs[p]);
			if (p == 1) begin
				// Narrow counters: fan 0 divides by 1, fan 1 by 128, others by 2.
				send_reading(make_req(CMD_FAN, 4'd0, 16'hFF00), 0);
				send_reading(make_req(CMD_FAN, 4'd0, 16'h0001), 0);
				send_reading(make_req(CMD_FAN, 4'd1, 16'h00FE), 0);
				send_reading(make_req(CMD_FAN, 4'd1, 16'h0001), 0);
				send_reading(make_req(CMD_FAN, 4'd9, 16'h12FF), 0);
				send_reading(make_req(CMD_FAN, 4'd14, 16'h0001), 0);
			end
			send_random_readings(RANDOM_PER_PHASE);
		end
		drain_readings();

		$display("Checked %0d readings (%0d valid) of all four kinds under %0d register settings,",
			readings_checked, readings_valid, settings_used);
		$display("covering every step mode, both fan counter widths and divisor extremes.");
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
